// ===== sv/lpfd_pkg.sv =====
// shared types, constants and md5 tables for the length-prefixed field deframer
package lpfd_pkg;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam int unsigned TAIL_SKIP  = 37;
    localparam int unsigned DL_AW      = 6;
    localparam int unsigned DIG_CHARS  = 32;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HDR  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FEW      = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;

    localparam logic [127:0] MD5_INIT = 128'h10325476_98badcfe_efcdab89_67452301;

    localparam logic [31:0] MD5_K [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_ROT [0:15] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used in a round
    function automatic logic [3:0] md5_g(input logic [5:0] r);
        logic [5:0] t;
        begin
            t = 6'd0;
            case (r[5:4])
                2'd0: t = r;
                2'd1: t = 6'(r * 6'd5 + 6'd1);
                2'd2: t = 6'(r * 6'd3 + 6'd5);
                default: t = 6'(r * 6'd7);
            endcase
            md5_g = t[3:0];
        end
    endfunction

    // hex character to {valid, nibble}
    function automatic logic [4:0] hex_nib(input logic [7:0] ch);
        begin
            if (ch >= 8'h30 && ch <= 8'h39) hex_nib = {1'b1, 4'(ch - 8'h30)};
            else if (ch >= 8'h61 && ch <= 8'h66) hex_nib = {1'b1, 4'(ch - 8'h57)};
            else if (ch >= 8'h41 && ch <= 8'h46) hex_nib = {1'b1, 4'(ch - 8'h37)};
            else hex_nib = 5'd0;
        end
    endfunction

    typedef struct packed {
        logic step;
        logic pad_begin;
        logic compare;
        logic load_status;
        logic clear;
    } lpfd_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic need_digest;
    } lpfd_sts_t;

    typedef struct packed {
        logic       feed;
        logic [7:0] feed_byte;
        logic       pad_begin;
        logic       clear;
    } lpfd_md5_cmd_t;

endpackage

// ===== sv/lpfd_md5.sv =====
// md5 engine: byte intake, block store, one round per cycle, padding
module lpfd_md5 (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lpfd_pkg::lpfd_md5_cmd_t cmd,
    output logic                   busy,
    output logic [127:0]           chain
);
    import lpfd_pkg::*;

    typedef enum logic [3:0] {
        PAD_OFF   = 4'b0001,
        PAD_FIRST = 4'b0010,
        PAD_ZERO  = 4'b0100,
        PAD_LEN   = 4'b1000
    } pad_t;

    logic [127:0] chain_reg;
    logic [63:0]  cnt_reg, bits_reg;
    logic [23:0]  part_reg;
    logic [31:0]  blk_mem [0:15];
    logic [31:0]  w_reg;
    logic         comp_reg, fin_reg;
    logic [5:0]   rnd_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    pad_t         pad_reg, pad_next;
    logic [2:0]   len_idx_reg;

    logic [5:0]  at;
    logic        idle_eng, pad_feed, wr_en;
    logic [7:0]  wr_byte;
    logic [31:0] f, tmp, b_new;
    logic [63:0] rot2;
    logic [4:0]  s;

    assign at       = cnt_reg[8:3];
    assign idle_eng = !comp_reg && !fin_reg;
    assign busy     = comp_reg || fin_reg || (pad_reg != PAD_OFF);
    assign chain    = chain_reg;

    // padding byte source
    always_comb begin
        pad_feed = 1'b0;
        wr_byte  = cmd.feed_byte;
        pad_next = pad_reg;
        case (pad_reg)
            PAD_FIRST: begin
                if (idle_eng) begin
                    pad_feed = 1'b1;
                    wr_byte  = 8'h80;
                    pad_next = PAD_ZERO;
                end
            end
            PAD_ZERO: begin
                if (idle_eng) begin
                    if (at == 6'd56) begin
                        pad_next = PAD_LEN;
                    end else begin
                        pad_feed = 1'b1;
                        wr_byte  = 8'h00;
                    end
                end
            end
            PAD_LEN: begin
                if (idle_eng) begin
                    pad_feed = 1'b1;
                    wr_byte  = bits_reg[8*len_idx_reg +: 8];
                    if (len_idx_reg == 3'd7) pad_next = PAD_OFF;
                end
            end
            default: ;
        endcase
    end

    assign wr_en = cmd.feed || pad_feed;

    // round function
    always_comb begin
        case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        s     = MD5_ROT[{rnd_reg[5:4], rnd_reg[1:0]}];
        tmp   = a_reg + f + MD5_K[rnd_reg] + w_reg;
        rot2  = {tmp, tmp} << s;
        b_new = b_reg + rot2[63:32];
    end

    // block store, written a word at a time, read one word per round
    always_ff @(posedge aclk) begin
        if (wr_en && at[1:0] == 2'd3) begin
            blk_mem[at[5:2]] <= {wr_byte, part_reg};
        end
        w_reg <= blk_mem[comp_reg ? md5_g(rnd_reg + 6'd1) : 4'd0];
    end

    // partial word assembly
    always_ff @(posedge aclk) begin
        if (wr_en && at[1:0] != 2'd3) begin
            part_reg[8*at[1:0] +: 8] <= wr_byte;
        end
    end

    // byte count, compression control, padding sequence
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            chain_reg   <= MD5_INIT;
            cnt_reg     <= 64'd0;
            comp_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            rnd_reg     <= 6'd0;
            pad_reg     <= PAD_OFF;
            len_idx_reg <= 3'd0;
        end else begin
            pad_reg <= pad_next;
            if (cmd.pad_begin) begin
                pad_reg     <= PAD_FIRST;
                bits_reg    <= cnt_reg;
                len_idx_reg <= 3'd0;
            end
            if (pad_reg == PAD_LEN && pad_feed) begin
                len_idx_reg <= len_idx_reg + 3'd1;
            end
            if (wr_en) begin
                cnt_reg <= cnt_reg + 64'd8;
                if (at == 6'd63) begin
                    comp_reg <= 1'b1;
                    rnd_reg  <= 6'd0;
                    a_reg    <= chain_reg[31:0];
                    b_reg    <= chain_reg[63:32];
                    c_reg    <= chain_reg[95:64];
                    d_reg    <= chain_reg[127:96];
                end
            end
            if (comp_reg) begin
                a_reg   <= d_reg;
                d_reg   <= c_reg;
                c_reg   <= b_reg;
                b_reg   <= b_new;
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    comp_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                fin_reg   <= 1'b0;
                chain_reg <= {chain_reg[127:96] + d_reg, chain_reg[95:64] + c_reg,
                              chain_reg[63:32] + b_reg, chain_reg[31:0] + a_reg};
            end
        end
    end

    // a byte from outside never lands while the engine works
    a_feed_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.feed |-> !busy) else $error("md5 feed while busy");
    // rounds and final add never overlap
    a_comp_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        !(comp_reg && fin_reg)) else $error("md5 round and final add overlap");
    // last round hands over to the final add
    a_last_round: assert property (@(posedge aclk) disable iff (!aresetn || cmd.clear)
        (comp_reg && rnd_reg == 6'd63) |=> fin_reg) else $error("md5 final add missed");

endmodule

// ===== sv/lpfd_datapath.sv =====
// field parser, hash delay line, digest store and result register
module lpfd_datapath #(
    parameter int LENGTH_BITS = 16,
    parameter int INDEX_BITS  = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic [7:0]              in_byte,
    input  logic                    in_eom,
    input  lpfd_pkg::lpfd_cmd_t     cmd,
    input  logic [127:0]            chain,
    output lpfd_pkg::lpfd_sts_t     sts,
    output lpfd_pkg::lpfd_md5_cmd_t md5_cmd,
    input  logic                    out_ready,
    output logic                    out_kind,
    output logic [7:0]              out_index,
    output logic [7:0]              out_value,
    output logic                    out_end,
    output logic [2:0]              out_status,
    output logic                    out_final
);
    import lpfd_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam int IB = INDEX_BITS;
    localparam logic [IB-1:0] IMAX = (IB >= 8) ? IB'(255) : {IB{1'b1}};
    localparam logic [DL_AW-1:0] DL_LAST = DL_AW'(TAIL_SKIP - 1);
    localparam logic [DL_AW-1:0] DL_FULL = DL_AW'(TAIL_SKIP);

    typedef enum logic [6:0] {
        PH_LEAD   = 7'b0000001,
        PH_TYPE   = 7'b0000010,
        PH_DIGITS = 7'b0000100,
        PH_TAIL   = 7'b0001000,
        PH_VALUE  = 7'b0010000,
        PH_SKIP   = 7'b0100000,
        PH_DEAD   = 7'b1000000
    } phase_t;

    logic          check_reg;
    phase_t        phase_reg, phase_next;
    logic [LB-1:0] acc_reg, acc_next, rem_reg, rem_next;
    logic [IB-1:0] fc_reg, fc_next;
    logic [7:0]    cur_reg, cur_next;
    logic [2:0]    err_reg, err_next;
    logic [31:0]   pos_reg, pos_next, hs_reg, hs_next;
    logic [5:0]    dfill_reg, dfill_next;
    logic [7:0]    dig_reg [0:DIG_CHARS-1];
    logic [7:0]    dl_mem [0:TAIL_SKIP-1];
    logic [DL_AW-1:0] ptr_reg, ptr_next, dl_fill_reg;
    logic [7:0]    dl_rd_reg;
    logic [2:0]    st_reg, st_pre;
    logic          need_reg, mis_reg, mismatch;
    logic          val_res, open_f, dig_wr, hash_en;
    logic [LB+3:0] acc_x10;
    logic [32:0]   hs_sum;

    logic          ov_reg, kind_reg, end_reg, fin_reg;
    logic [7:0]    idx_reg, vb_reg;
    logic [2:0]    ost_reg;

    // parser next state
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        fc_next    = fc_reg;
        cur_next   = cur_reg;
        err_next   = err_reg;
        hs_next    = hs_reg;
        dfill_next = dfill_reg;
        val_res    = 1'b0;
        open_f     = 1'b0;
        dig_wr     = 1'b0;
        acc_x10    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {{LB{1'b0}}, 4'(in_byte - 8'h30)};
        hs_sum     = {1'b0, pos_reg} + 33'd1 + 33'(acc_reg);
        case (phase_reg)
            PH_LEAD: begin
                if (in_byte == CH_COLON) phase_next = PH_TYPE;
                else begin
                    err_next = ST_BAD_HDR;
                    phase_next = PH_DEAD;
                end
            end
            PH_TYPE: begin
                if (in_byte == CH_COLON) begin
                    err_next   = (fc_reg == '0) ? ST_BAD_HDR : ST_EMPTY;
                    phase_next = PH_DEAD;
                end else if (fc_reg == '0 && in_byte != CH_I) begin
                    err_next   = ST_BAD_HDR;
                    phase_next = PH_DEAD;
                end else begin
                    acc_next   = '0;
                    phase_next = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (in_byte == CH_COLON) open_f = 1'b1;
                else if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
                    acc_next = (acc_x10[LB+3:LB] != 4'd0) ? {LB{1'b1}} : acc_x10[LB-1:0];
                end else phase_next = PH_TAIL;
            end
            PH_TAIL: begin
                if (in_byte == CH_COLON) open_f = 1'b1;
            end
            PH_VALUE: begin
                val_res = 1'b1;
                if (dfill_reg < 6'(DIG_CHARS)) begin
                    dig_wr     = 1'b1;
                    dfill_next = dfill_reg + 6'd1;
                end
                rem_next = rem_reg - LB'(1);
                if (rem_reg == LB'(1)) phase_next = PH_SKIP;
            end
            PH_SKIP: phase_next = PH_TYPE;
            default: ;
        endcase
        // opening a field after its type
        if (open_f) begin
            cur_next = 8'(fc_reg);
            if (fc_reg < IMAX) fc_next = fc_reg + IB'(1);
            if (fc_reg == '0) hs_next = hs_sum[32] ? 32'hffffffff : hs_sum[31:0];
            dfill_next = 6'd0;
            if (acc_reg == '0) phase_next = PH_SKIP;
            else begin
                rem_next   = acc_reg;
                phase_next = PH_VALUE;
            end
        end
        pos_next = (pos_reg != 32'hffffffff) ? pos_reg + 32'd1 : pos_reg;
        // status known at the end of the message
        st_pre = err_next;
        if (st_pre == ST_OK && (fc_next == '0 || pos_next < hs_next)) st_pre = ST_BAD_HDR;
        if (st_pre == ST_OK && fc_next <= IB'(2)) st_pre = ST_FEW;
    end

    // hash delay line control
    assign hash_en  = cmd.step && fc_reg != '0 && pos_reg >= hs_reg;
    assign ptr_next = cmd.clear ? '0 :
                      hash_en ? ((ptr_reg == DL_LAST) ? '0 : ptr_reg + DL_AW'(1)) : ptr_reg;

    always_comb begin
        md5_cmd.feed      = hash_en && dl_fill_reg == DL_FULL;
        md5_cmd.feed_byte = dl_rd_reg;
        md5_cmd.pad_begin = cmd.pad_begin;
        md5_cmd.clear     = cmd.clear;
    end

    // delay line memory
    always_ff @(posedge aclk) begin
        if (hash_en) dl_mem[ptr_reg] <= in_byte;
        dl_rd_reg <= dl_mem[ptr_next];
    end

    // digest characters of the current field
    always_ff @(posedge aclk) begin
        if (cmd.step && dig_wr) dig_reg[dfill_reg[4:0]] <= in_byte;
    end

    // compare the digest against the hex characters
    always_comb begin
        logic [7:0] c1, c2, want, got;
        logic [4:0] h1, h2;
        mismatch = 1'b0;
        for (int i = 0; i < 16; i++) begin
            c1   = (6'(2*i) < dfill_reg) ? dig_reg[2*i] : 8'd0;
            c2   = (6'(2*i+1) < dfill_reg) ? dig_reg[2*i+1] : 8'd0;
            h1   = hex_nib(c1);
            h2   = hex_nib(c2);
            want = !h1[4] ? 8'd0 : (h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]});
            got  = chain[8*i +: 8];
            if (want != got) mismatch = 1'b1;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) check_reg <= 1'b0;
        else if (cfg_we) check_reg <= cfg_wdata;
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            phase_reg   <= PH_LEAD;
            acc_reg     <= '0;
            rem_reg     <= '0;
            fc_reg      <= '0;
            cur_reg     <= 8'd0;
            err_reg     <= ST_OK;
            pos_reg     <= 32'd0;
            hs_reg      <= 32'd0;
            dfill_reg   <= 6'd0;
            ptr_reg     <= '0;
            dl_fill_reg <= '0;
            need_reg    <= 1'b0;
            mis_reg     <= 1'b0;
            st_reg      <= ST_OK;
        end else begin
            if (cmd.step) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                rem_reg   <= rem_next;
                fc_reg    <= fc_next;
                cur_reg   <= cur_next;
                err_reg   <= err_next;
                pos_reg   <= pos_next;
                hs_reg    <= hs_next;
                dfill_reg <= dfill_next;
                if (in_eom) begin
                    st_reg   <= st_pre;
                    need_reg <= (st_pre == ST_OK) && check_reg;
                end
            end
            ptr_reg <= ptr_next;
            if (hash_en && dl_fill_reg != DL_FULL) dl_fill_reg <= dl_fill_reg + DL_AW'(1);
            if (cmd.compare) mis_reg <= mismatch;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            if (cmd.step && val_res) ov_reg <= 1'b1;
            if (cmd.load_status) ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && val_res) begin
            kind_reg <= 1'b0;
            idx_reg  <= cur_reg;
            vb_reg   <= in_byte;
            end_reg  <= (rem_reg == LB'(1)) || in_eom;
            ost_reg  <= ST_OK;
            fin_reg  <= !in_eom;
        end else if (cmd.load_status) begin
            kind_reg <= 1'b1;
            idx_reg  <= 8'd0;
            vb_reg   <= 8'd0;
            end_reg  <= 1'b0;
            ost_reg  <= mis_reg ? ST_MISMATCH : st_reg;
            fin_reg  <= 1'b1;
        end
    end

    assign sts.out_valid   = ov_reg;
    assign sts.need_digest = need_reg;
    assign out_kind   = kind_reg;
    assign out_index  = idx_reg;
    assign out_value  = vb_reg;
    assign out_end    = end_reg;
    assign out_status = ost_reg;
    assign out_final  = fin_reg;

endmodule

// ===== sv/lpfd_ctrl.sv =====
// message sequencer: byte intake, end-of-message digest and status
module lpfd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_eom,
    output logic                in_ready,
    input  logic                md5_busy,
    input  lpfd_pkg::lpfd_sts_t sts,
    output lpfd_pkg::lpfd_cmd_t cmd
);
    import lpfd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIN  = 4'b0010,
        S_PAD  = 4'b0100,
        S_STAT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = !md5_busy && !sts.out_valid;
                if (in_valid && in_ready) begin
                    cmd.step = 1'b1;
                    if (in_eom) state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!md5_busy && !sts.out_valid) begin
                    if (sts.need_digest) begin
                        cmd.pad_begin = 1'b1;
                        state_next    = S_PAD;
                    end else begin
                        state_next = S_STAT;
                    end
                end
            end
            S_PAD: begin
                if (!md5_busy) begin
                    cmd.compare = 1'b1;
                    state_next  = S_STAT;
                end
            end
            S_STAT: begin
                if (!sts.out_valid) begin
                    cmd.load_status = 1'b1;
                    cmd.clear       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    // a byte is taken only while no result waits
    a_step_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !sts.out_valid) else $error("byte taken with result pending");
    // status goes out only over an empty result register
    a_stat_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_status |-> !sts.out_valid) else $error("status overwrote result");
    // after the status the sequencer is back to intake
    a_stat_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_status |=> state_reg == S_IDLE) else $error("no return to intake");

endmodule

// ===== sv/length_prefixed_field_deframer_top.sv =====
// top level of the length-prefixed field deframer with md5 check
//
// channel | ports                         | payload
// input   | s_tvalid s_tready s_tdata s_tlast | data byte, end of message
// result  | m_tvalid m_tready m_tdata m_tlast m_tuser | value byte or status
// config  | cfg_we cfg_wdata              | digest_check
//
// a byte that yields no result does not make the next byte wait for the result
// register; after a value byte the next byte waits until it is emptied.
// every 64 hashed bytes the md5 unit runs 64 rounds and a final add, and the
// input stalls meanwhile; at message end with checking on and a good status,
// padding and one or two more compressions precede the status.
// reset is synchronous and needs no clearing pass; a stall on m_tready holds
// the result and the input alike.
module length_prefixed_field_deframer_top #(
    parameter int LENGTH_BITS = 16,
    parameter int INDEX_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] field_index, [15:8] value_byte,
                                   // [18:16] status, [19] final_res, rest zero
    output logic        m_tlast,   // field_end
    output logic        m_tuser    // kind
);
    import lpfd_pkg::*;

    lpfd_cmd_t     cmd;
    lpfd_sts_t     sts;
    lpfd_md5_cmd_t md5_cmd;
    logic          md5_busy;
    logic [127:0]  chain;
    logic [7:0]    o_index, o_value;
    logic [2:0]    o_status;
    logic          o_final;

    lpfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_eom   (s_tlast),
        .in_ready (s_tready),
        .md5_busy (md5_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpfd_datapath #(
        .LENGTH_BITS (LENGTH_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_byte    (s_tdata),
        .in_eom     (s_tlast),
        .cmd        (cmd),
        .chain      (chain),
        .sts        (sts),
        .md5_cmd    (md5_cmd),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_index  (o_index),
        .out_value  (o_value),
        .out_end    (m_tlast),
        .out_status (o_status),
        .out_final  (o_final)
    );

    lpfd_md5 u_md5 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (md5_cmd),
        .busy    (md5_busy),
        .chain   (chain)
    );

    assign m_tvalid = sts.out_valid;
    assign m_tdata  = {4'd0, o_final, o_status, o_value, o_index};

endmodule

// ===== sim/tb_length_prefixed_field_deframer_top.sv =====
// testbench for the length-prefixed field deframer: table-driven and random messages checked against a predictor
`timescale 1ns / 100ps

module tb_length_prefixed_field_deframer_top;
    import lpfd_pkg::*;

    typedef enum logic [2:0] {
        P_LEAD, P_TYPE, P_DIGITS, P_TAIL, P_VALUE, P_SKIP, P_DEAD
    } parse_phase_t;

    typedef struct {
        bit       kind;
        bit [7:0] idx;
        bit [7:0] val;
        bit       fend;
        bit [2:0] st;
        bit       fin;
    } deframe_rec_t;

    typedef struct {
        string    msg;
        bit       chk;
        bit       has_st;
        bit [2:0] st;
    } msg_row_t;

    localparam int LEN_MAX = 65535;
    localparam int IDX_MAX = 255;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // predictor state
    parse_phase_t ph;
    int           len_acc, remaining, fcount, cur_idx;
    bit [2:0]     err_code;
    longint       bpos, hstart;
    logic [7:0]   hashed_q[$];
    logic [7:0]   digest_chars[$];
    bit           check_on = 1'b0;
    bit           force_st_en = 1'b0;
    bit [2:0]     force_st;

    deframe_rec_t want_q[$];
    deframe_rec_t got_rec;
    int           errs = 0;
    int           s_idle = 0;
    int           r_idle = 0;
    int           sent = 0;

    length_prefixed_field_deframer_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // md5 of a whole byte string, digest byte i in bits [8i+7:8i]
    function automatic logic [127:0] md5_of(input logic [7:0] msg[$]);
        logic [31:0] h[4];
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, t, x;
        logic [7:0]  blk[$];
        logic [63:0] bits;
        int          g, s;
        blk = msg;
        bits = 64'(msg.size()) * 8;
        blk.insert(blk.size(), 8'h80);
        while (blk.size() % 64 != 56) blk.insert(blk.size(), 8'h00);
        for (int i = 0; i < 8; i++) blk.insert(blk.size(), bits[8*i +: 8]);
        for (int i = 0; i < 4; i++) h[i] = MD5_INIT[32*i +: 32];
        for (int base = 0; base < blk.size(); base += 64) begin
            for (int i = 0; i < 16; i++)
                w[i] = {blk[base+4*i+3], blk[base+4*i+2], blk[base+4*i+1], blk[base+4*i]};
            a = h[0]; b = h[1]; c = h[2]; d = h[3];
            for (int i = 0; i < 64; i++) begin
                if (i < 16) begin f = (b & c) | (~b & d); g = i; end
                else if (i < 32) begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
                else if (i < 48) begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
                else begin f = c ^ (b | ~d); g = (7*i) % 16; end
                s = MD5_ROT[((i / 16) * 4) + (i % 4)];
                x = a + f + MD5_K[i] + w[g];
                t = d; d = c; c = b;
                b = b + ((x << s) | (x >> (32 - s)));
                a = t;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        end
        return {h[3], h[2], h[1], h[0]};
    endfunction

    // hex character value, -1 when not hex
    function automatic int hex_digit(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return ch - "0";
        if (ch >= "a" && ch <= "f") return ch - "a" + 10;
        if (ch >= "A" && ch <= "F") return ch - "A" + 10;
        return -1;
    endfunction

    task automatic clear_message();
        ph = P_LEAD;
        len_acc = 0; remaining = 0; fcount = 0; cur_idx = 0;
        err_code = ST_OK; bpos = 0; hstart = 0;
        hashed_q.delete();
        digest_chars.delete();
    endtask

    task automatic halt_parse(input bit [2:0] code);
        err_code = code;
        ph = P_DEAD;
    endtask

    task automatic open_field(input longint pos);
        cur_idx = fcount;
        if (fcount == 0) hstart = pos + 1 + len_acc;
        if (fcount < IDX_MAX) fcount++;
        digest_chars.delete();
        if (len_acc == 0) ph = P_SKIP;
        else begin
            remaining = len_acc;
            ph = P_VALUE;
        end
    endtask

    // one accepted request: queue the results it should cause
    task automatic deframe_step(input logic [7:0] b, input logic eom);
        deframe_rec_t r;
        logic [7:0]   body[$];
        logic [127:0] dg;
        bit [2:0]     st;
        int           h1, h2;
        bit [7:0]     want;
        longint       pos;
        pos = bpos;
        case (ph)
            P_LEAD: if (b == CH_COLON) ph = P_TYPE; else halt_parse(ST_BAD_HDR);
            P_TYPE: begin
                if (b == CH_COLON) halt_parse(fcount == 0 ? ST_BAD_HDR : ST_EMPTY);
                else if (fcount == 0 && b != CH_I) halt_parse(ST_BAD_HDR);
                else begin len_acc = 0; ph = P_DIGITS; end
            end
            P_DIGITS: begin
                if (b == CH_COLON) open_field(pos);
                else if (b >= "0" && b <= "9") begin
                    len_acc = len_acc * 10 + (b - "0");
                    if (len_acc > LEN_MAX) len_acc = LEN_MAX;
                end else ph = P_TAIL;
            end
            P_TAIL: if (b == CH_COLON) open_field(pos);
            P_VALUE: begin
                r = '{1'b0, 8'(cur_idx), b, (remaining == 1 || eom), ST_OK, !eom};
                want_q.insert(want_q.size(), r);
                if (digest_chars.size() < DIG_CHARS) digest_chars.insert(digest_chars.size(), b);
                remaining--;
                if (remaining == 0) ph = P_SKIP;
            end
            P_SKIP: ph = P_TYPE;
            default: ;
        endcase
        if (fcount > 0 && pos >= hstart) hashed_q.insert(hashed_q.size(), b);
        bpos++;
        if (eom) begin
            st = err_code;
            if (st == ST_OK && (fcount == 0 || bpos < hstart)) st = ST_BAD_HDR;
            if (st == ST_OK && fcount <= 2) st = ST_FEW;
            if (st == ST_OK && check_on) begin
                // the newest bytes stay in the delay line and are never hashed
                if (hashed_q.size() > TAIL_SKIP) body = hashed_q[0 : hashed_q.size() - TAIL_SKIP - 1];
                dg = md5_of(body);
                for (int i = 0; i < 16; i++) begin
                    h1 = (2*i < digest_chars.size()) ? hex_digit(digest_chars[2*i]) : -1;
                    h2 = (2*i + 1 < digest_chars.size()) ? hex_digit(digest_chars[2*i+1]) : -1;
                    want = 0;
                    if (h1 >= 0) want = (h2 >= 0) ? 8'(h1 * 16 + h2) : 8'(h1);
                    if (want != dg[8*i +: 8]) st = ST_MISMATCH;
                end
            end
            if (force_st_en) st = force_st;
            force_st_en = 1'b0;
            r = '{1'b1, 8'd0, 8'd0, 1'b0, st, 1'b1};
            want_q.insert(want_q.size(), r);
            clear_message();
        end
    endtask

    // input request monitor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) deframe_step(s_tdata, s_tlast);
    end

    // result monitor and checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (want_q.size() == 0) begin
                $error("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser);
                errs++;
            end else begin
                got_rec = want_q.pop_front();
                if (m_tuser !== got_rec.kind) begin
                    $error("kind: expected %0d got %0d", got_rec.kind, m_tuser); errs++;
                end
                if (m_tdata[7:0] !== got_rec.idx) begin
                    $error("field_index: expected %0d got %0d", got_rec.idx, m_tdata[7:0]);
                    errs++;
                end
                if (m_tdata[15:8] !== got_rec.val) begin
                    $error("value_byte: expected %h got %h", got_rec.val, m_tdata[15:8]);
                    errs++;
                end
                if (m_tlast !== got_rec.fend) begin
                    $error("field_end: expected %0d got %0d", got_rec.fend, m_tlast); errs++;
                end
                if (m_tdata[18:16] !== got_rec.st) begin
                    $error("status: expected %0d got %0d", got_rec.st, m_tdata[18:16]); errs++;
                end
                if (m_tdata[19] !== got_rec.fin) begin
                    $error("final_res: expected %0d got %0d", got_rec.fin, m_tdata[19]); errs++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= r_idle);

    task automatic put_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < s_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic put_message(input logic [7:0] msg[$]);
        foreach (msg[i]) put_byte(msg[i], i == msg.size() - 1);
    endtask

    // hold the sender until every expected result is out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (want_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_check(input bit v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        check_on = v;
    endtask

    task automatic add_num(ref logic [7:0] q[$], input int n);
        string s;
        s.itoa(n);
        for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    endtask

    task automatic add_bytes(ref logic [7:0] q[$], input int n);
        for (int i = 0; i < n; i++) q.insert(q.size(), 8'($urandom));
    endtask

    // random message: mostly well formed with a correct digest field
    task automatic build_message(ref logic [7:0] q[$]);
        int           pick, n, hs, v;
        logic [7:0]   body[$];
        logic [127:0] dg;
        logic [7:0]   ch;
        q.delete();
        pick = $urandom_range(99);
        if (pick >= 90) begin
            if ($urandom_range(1)) begin q.insert(q.size(), CH_COLON); q.insert(q.size(), CH_I); end
            add_bytes(q, $urandom_range(1, 20));
            return;
        end
        q.insert(q.size(), CH_COLON);
        q.insert(q.size(), CH_I);
        n = $urandom_range(0, 5);
        add_num(q, n);
        q.insert(q.size(), CH_COLON);
        hs = q.size() + n;
        add_bytes(q, n + 1);
        repeat ($urandom_range(1, 4)) begin
            do ch = 8'($urandom); while (ch == CH_COLON);
            q.insert(q.size(), ch);
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 4);
            add_num(q, n);
            if ($urandom_range(5) == 0) begin q.insert(q.size(), "z"); q.insert(q.size(), "q"); end
            q.insert(q.size(), CH_COLON);
            add_bytes(q, n + 1);
        end
        if (hs <= q.size() - 2) body = q[hs : q.size() - 2];
        dg = md5_of(body);
        q.insert(q.size(), "d"); q.insert(q.size(), "3");
        q.insert(q.size(), "2"); q.insert(q.size(), CH_COLON);
        for (int i = 0; i < 32; i++) begin
            v = dg[4*(i ^ 1) +: 4];
            ch = (v < 10) ? 8'("0" + v) : ($urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10));
            q.insert(q.size(), ch);
        end
        if (pick >= 70 && pick < 80) begin
            n = q.size() - 1 - $urandom_range(31);
            q[n] = (q[n] == "5") ? 8'("6") : 8'("5");
        end else if (pick >= 80) begin
            q = q[0 : $urandom_range(q.size() - 1)];
        end
    endtask

    msg_row_t rows[] = '{
        '{":x3:abc",            1'b0, 1'b1, ST_BAD_HDR},
        '{"a",                  1'b0, 1'b1, ST_BAD_HDR},
        '{"::",                 1'b0, 1'b1, ST_BAD_HDR},
        '{":i3",                1'b0, 1'b1, ST_BAD_HDR},
        '{":i5:ab",             1'b0, 1'b1, ST_BAD_HDR},
        '{":i99999:\377\200",   1'b0, 1'b1, ST_BAD_HDR},
        '{":i2:ab::zz",         1'b0, 1'b1, ST_EMPTY},
        '{":i2:ab:x1:c",        1'b0, 1'b1, ST_FEW},
        '{":i0::x0::",          1'b0, 1'b1, ST_FEW},
        '{":i2:ab:x1:c:y1:d",   1'b0, 1'b1, ST_OK},
        '{":i1z9:q:a2:bc:b3:d", 1'b0, 1'b0, ST_OK},
        '{":i1:q:a99999:xyz",   1'b0, 1'b0, ST_OK},
        '{":i2:ab:x1:c:y1:d",   1'b1, 1'b1, ST_MISMATCH},
        '{":i1:q:x2:::y3:0g",   1'b1, 1'b0, ST_OK}
    };

    initial begin
        logic [7:0] q[$];
        int         base;
        clear_message();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed messages
        foreach (rows[k]) begin
            if (rows[k].chk != check_on) write_check(rows[k].chk);
            q.delete();
            for (int i = 0; i < rows[k].msg.len(); i++) q.insert(q.size(), rows[k].msg[i]);
            foreach (q[i]) begin
                if (i == q.size() - 1) begin
                    wait (want_q.size() == 0);
                    force_st_en = rows[k].has_st;
                    force_st = rows[k].st;
                end
                put_byte(q[i], i == q.size() - 1);
            end
        end

        // field index saturation
        write_check(1'b0);
        q.delete();
        q = '{":", "i", "0", ":", ":"};
        repeat (260) begin
            q.insert(q.size(), "x"); q.insert(q.size(), ":"); q.insert(q.size(), ":");
        end
        q.insert(q.size(), "y"); q.insert(q.size(), "2"); q.insert(q.size(), ":");
        add_bytes(q, 2);
        put_message(q);

        // random phases with different idle mixes
        base = sent;
        for (int p = 0; p < 4; p++) begin
            write_check(p == 1 || p == 2);
            case (p)
                0: begin s_idle = 0;  r_idle = 0;  end
                1: begin s_idle = 51; r_idle = 0;  end
                2: begin s_idle = 0;  r_idle = 51; end
                default: begin s_idle = 17; r_idle = 17; end
            endcase
            while (sent < base + 50 * (p + 1)) begin
                build_message(q);
                put_message(q);
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        if (errs == 0) $display("[length_prefixed_field_deframer_top] OK");
        else $display("[length_prefixed_field_deframer_top] ERROR");
        $finish;
    end

    // overall time limit
    initial begin
        #50ms;
        $display("[length_prefixed_field_deframer_top] ERROR");
        $finish;
    end

endmodule
